>>> rtl/epnno_pkg.sv
`timescale 1ns / 1ps
package epnno_pkg;
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W = $clog2(MAX_COLS + 1);
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int DIST_W = 2 * (ROW_W > COL_W ? ROW_W : COL_W) + 1;
	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_FETCH = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1
	} reg_idx_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		logic [ADDR_W:0] a;
		a = (ADDR_W+1)'(r) * (ADDR_W+1)'(MAX_COLS) + (ADDR_W+1)'(c);
		return a[ADDR_W-1:0];
	endfunction
endpackage

>>> rtl/edge_pixel_nearest_neighbour_order.sv
`timescale 1ns / 1ps
// A load, restart or other non-fetch word is taken only while idle.
// The load of the last in-use pixel starts an edge build over every in-use pixel.
// A fetch with edge pixels left scans the edge map, one edge-map read per cycle.
// An empty edge set or an incomplete load answers a fetch in the next cycle, without a scan.
// Reset clears all control state and sets both size registers to 64; no memory clearing pass.
module edge_pixel_nearest_neighbour_order
	import epnno_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic                 pixel_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [5:0]           point_row,
	output logic [5:0]           point_col,
	output logic                 point_valid,
	output logic                 point_last
);
	typedef enum logic [1:0] {ST_IDLE, ST_BUILD, ST_SCAN} state_t;
	typedef enum logic [1:0] {PH_LOADING, PH_FIRST, PH_NEXT} phase_t;

	logic shape_mem [CELLS];
	logic edge_mem [CELLS];

	state_t state_q;
	phase_t phase_q;
	logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [RCNT_W-1:0] nr;
	logic [CCNT_W-1:0] nc;
	logic [ROW_W-1:0] lr_q, br_q, sr_q, cur_r_q, r_s1, r_s2, best_r_q, fin_r;
	logic [COL_W-1:0] lc_q, bc_q, sc_q, cur_c_q, c_s1, c_s2, best_c_q, fin_c;
	logic [CNT_W-1:0] remain_q;
	logic [3:0] k_q;
	logic [1:0] kr, kc;
	logic self_q, clr_q, self_n, clr_n;
	logic v_s1, ok_s1, ctr_s1, last_s1, v_s2, last_s2, issue_q, found_q, upd;
	logic shape_rd_q, edge_rd_q;
	logic [DIST_W-1:0] d_s2, best_d_q, dist_n;
	logic signed [ROW_W+1:0] rr;
	logic signed [COL_W+1:0] cc;
	logic nb_ok;
	logic acc, is_last_cell;
	logic [ROW_W-1:0] dr;
	logic [COL_W-1:0] dc;
	logic [ADDR_W-1:0] shape_raddr, edge_raddr, edge_waddr;
	logic edge_we, edge_wd;

	assign nr = (rows_cfg_q == '0) ? RCNT_W'(1) :
		(rows_cfg_q > CFG_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : RCNT_W'(rows_cfg_q);
	assign nc = (cols_cfg_q == '0) ? CCNT_W'(1) :
		(cols_cfg_q > CFG_W'(MAX_COLS)) ? CCNT_W'(MAX_COLS) : CCNT_W'(cols_cfg_q);

	assign in_stall = (state_q != ST_IDLE) || (out_valid && command == CMD_FETCH);
	assign acc = in_valid && !in_stall;

	// Neighbor offsets follow k in raster order over the 3x3 window.
	always_comb begin
		kr = (k_q >= 4'd6) ? 2'd2 : (k_q >= 4'd3) ? 2'd1 : 2'd0;
		kc = 2'(k_q - {1'b0, kr, 1'b0} - {2'b00, kr});
		rr = $signed({2'b00, br_q}) + $signed((ROW_W+2)'(kr)) - $signed((ROW_W+2)'(1));
		cc = $signed({2'b00, bc_q}) + $signed((COL_W+2)'(kc)) - $signed((COL_W+2)'(1));
		nb_ok = (rr >= 0) && (rr < $signed((ROW_W+2)'(nr))) &&
			(cc >= 0) && (cc < $signed((COL_W+2)'(nc)));
		shape_raddr = cell_addr(rr[ROW_W-1:0], cc[COL_W-1:0]);
		self_n = self_q;
		clr_n = clr_q;
		if (v_s1) begin
			if (ctr_s1) begin
				self_n = shape_rd_q;
			end else if (ok_s1 && !shape_rd_q) begin
				clr_n = 1'b1;
			end
		end
	end

	assign is_last_cell = ({1'b0, br_q} == nr - 1'b1) && ({1'b0, bc_q} == nc - 1'b1);

	always_comb begin
		dr = (r_s1 > cur_r_q) ? r_s1 - cur_r_q : cur_r_q - r_s1;
		dc = (c_s1 > cur_c_q) ? c_s1 - cur_c_q : cur_c_q - c_s1;
		dist_n = DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dc) * DIST_W'(dc);
		upd = v_s2 && (!found_q || d_s2 < best_d_q);
		fin_r = upd ? r_s2 : best_r_q;
		fin_c = upd ? c_s2 : best_c_q;
		edge_raddr = cell_addr(sr_q, sc_q);
		edge_we = 1'b0;
		edge_wd = 1'b0;
		edge_waddr = cell_addr(br_q, bc_q);
		if (state_q == ST_BUILD && k_q == 4'd9) begin
			edge_we = 1'b1;
			edge_wd = self_n && clr_n;
		end else if (state_q == ST_SCAN && last_s2) begin
			edge_we = 1'b1;
			edge_waddr = cell_addr(fin_r, fin_c);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && command == CMD_LOAD && phase_q == PH_LOADING) begin
			shape_mem[cell_addr(lr_q, lc_q)] <= pixel_value;
		end
		shape_rd_q <= shape_mem[shape_raddr];
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_waddr] <= edge_wd;
		end
		edge_rd_q <= edge_mem[edge_raddr];
	end

	always_ff @(posedge clk) begin
		r_s1 <= sr_q;
		c_s1 <= sc_q;
		r_s2 <= r_s1;
		c_s2 <= c_s1;
		d_s2 <= (phase_q == PH_FIRST) ? '0 : dist_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_LOADING;
			rows_cfg_q <= CFG_W'(MAX_ROWS);
			cols_cfg_q <= CFG_W'(MAX_COLS);
			lr_q <= '0; lc_q <= '0; br_q <= '0; bc_q <= '0; sr_q <= '0; sc_q <= '0;
			cur_r_q <= '0; cur_c_q <= '0; best_r_q <= '0; best_c_q <= '0;
			best_d_q <= '0; found_q <= 1'b0;
			remain_q <= '0; k_q <= '0; self_q <= 1'b0; clr_q <= 1'b0;
			v_s1 <= 1'b0; ok_s1 <= 1'b0; ctr_s1 <= 1'b0; last_s1 <= 1'b0;
			v_s2 <= 1'b0; last_s2 <= 1'b0; issue_q <= 1'b0;
			out_valid <= 1'b0; point_row <= '0; point_col <= '0;
			point_valid <= 1'b0; point_last <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (cfg_we && (cfg_index == REG_ROWS || cfg_index == REG_COLS)) begin
				if (cfg_index == REG_ROWS) begin
					rows_cfg_q <= cfg_data;
				end else begin
					cols_cfg_q <= cfg_data;
				end
				phase_q <= PH_LOADING;
				remain_q <= '0;
				lr_q <= '0;
				lc_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (command)
							CMD_LOAD: begin
								if (phase_q == PH_LOADING) begin
									if ({1'b0, lc_q} == nc - 1'b1) begin
										lc_q <= '0;
										if ({1'b0, lr_q} == nr - 1'b1) begin
											state_q <= ST_BUILD;
											br_q <= '0; bc_q <= '0; k_q <= '0;
											self_q <= 1'b0; clr_q <= 1'b0;
											remain_q <= '0;
										end else begin
											lr_q <= lr_q + 1'b1;
										end
									end else begin
										lc_q <= lc_q + 1'b1;
									end
								end
							end
							CMD_RESTART: begin
								phase_q <= PH_LOADING;
								remain_q <= '0;
								lr_q <= '0;
								lc_q <= '0;
							end
							CMD_FETCH: begin
								if (phase_q == PH_LOADING || remain_q == '0) begin
									out_valid <= 1'b1;
									point_row <= '0; point_col <= '0;
									point_valid <= 1'b0; point_last <= 1'b0;
								end else begin
									state_q <= ST_SCAN;
									sr_q <= '0; sc_q <= '0; issue_q <= 1'b1;
									found_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_BUILD: begin
					v_s1 <= (k_q != 4'd9);
					ok_s1 <= nb_ok;
					ctr_s1 <= (k_q == 4'd4);
					if (k_q == 4'd9) begin
						k_q <= '0;
						self_q <= 1'b0;
						clr_q <= 1'b0;
						if (self_n && clr_n) begin
							remain_q <= remain_q + 1'b1;
						end
						if (is_last_cell) begin
							state_q <= ST_IDLE;
							phase_q <= PH_FIRST;
						end else if ({1'b0, bc_q} == nc - 1'b1) begin
							bc_q <= '0;
							br_q <= br_q + 1'b1;
						end else begin
							bc_q <= bc_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
						self_q <= self_n;
						clr_q <= clr_n;
					end
				end
				ST_SCAN: begin
					v_s1 <= issue_q;
					last_s1 <= issue_q && ({1'b0, sr_q} == nr - 1'b1) &&
						({1'b0, sc_q} == nc - 1'b1);
					v_s2 <= v_s1 && edge_rd_q;
					last_s2 <= v_s1 && last_s1;
					if (issue_q) begin
						if ({1'b0, sc_q} == nc - 1'b1) begin
							sc_q <= '0;
							if ({1'b0, sr_q} == nr - 1'b1) begin
								issue_q <= 1'b0;
							end else begin
								sr_q <= sr_q + 1'b1;
							end
						end else begin
							sc_q <= sc_q + 1'b1;
						end
					end
					if (upd) begin
						found_q <= 1'b1;
						best_d_q <= d_s2;
						best_r_q <= r_s2;
						best_c_q <= c_s2;
					end
					if (last_s2) begin
						state_q <= ST_IDLE;
						phase_q <= PH_NEXT;
						cur_r_q <= fin_r;
						cur_c_q <= fin_c;
						remain_q <= remain_q - 1'b1;
						out_valid <= 1'b1;
						point_row <= 6'(fin_r);
						point_col <= 6'(fin_c);
						point_valid <= 1'b1;
						point_last <= (remain_q == CNT_W'(1));
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input taken while busy");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= 4'd9)
		else $error("neighbour step out of range");
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && point_last |-> remain_q == '0)
		else $error("last point with edges left");
	a_loading_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LOADING && state_q == ST_IDLE |-> remain_q == '0)
		else $error("edge count set while loading");
endmodule
